@@ rtl/csp_pkg.sv @@
// Package of shared constants, register codes and types for the cell sum pooling block.
`timescale 1ns / 1ps

package csp_pkg;

  // Size limits of the block.
  localparam int MAX_CELLS_WIDE = 64;
  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_CELL_SIZE  = 16;
  localparam int MAX_CELLS_HIGH = 64;
  localparam int MAX_IMAGE_DIM  = 4096;
  localparam int MAX_CHANNELS   = 16;

  // Field and counter widths.
  localparam int SUM_W     = 24;
  localparam int POS_W     = 6;
  localparam int CHAN_W    = 4;
  localparam int PIX_W     = 12;
  localparam int IDX_W     = PIX_W + 1;
  localparam int CELL_W    = (MAX_CELL_SIZE > 1) ? $clog2(MAX_CELL_SIZE) : 1;
  localparam int ADDR_W    = (MAX_CELLS_WIDE > 1) ? $clog2(MAX_CELLS_WIDE) : 1;
  localparam int AREA_W    = 12;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE     = 3'd0,
    REG_CELLS_HIGH    = 3'd1,
    REG_CELLS_WIDE    = 3'd2,
    REG_IMAGE_ROWS    = 3'd3,
    REG_IMAGE_COLS    = 3'd4,
    REG_CHANNEL_COUNT = 3'd5
  } cfg_reg_e;

  // One finished cell.
  typedef struct packed {
    logic signed [SUM_W-1:0] cell_sum;
    logic [POS_W-1:0]        cell_row;
    logic [POS_W-1:0]        cell_col;
    logic [CHAN_W-1:0]       channel;
    logic                    frame_last;
  } result_t;

  // Work carried from the accept cycle into the accumulate stage.
  typedef struct packed {
    logic                    acc_en;
    logic                    first;
    logic                    emit;
    logic [ADDR_W-1:0]       addr;
    logic signed [SUM_W-1:0] sample;
    logic                    fwd;
    logic signed [SUM_W-1:0] fwd_data;
    logic [POS_W-1:0]        cell_row;
    logic [POS_W-1:0]        cell_col;
    logic [CHAN_W-1:0]       channel;
    logic                    frame_last;
  } stage_t;

endpackage

@@ rtl/csp_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module csp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]               wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]               rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a same-cycle write is not seen.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cell_sum_pooling_top.sv @@
// Top level of the cell sum pooling block: position counters, accumulator line and result queue.
`timescale 1ns / 1ps

// Sums each square cell of every channel plane of a raster-order image and emits
// one result per finished cell. The block takes one sample per clock cycle while the result
// queue has room, with no gaps of its own; the sample that closes a cell is held in the
// accumulate stage register and its result is then written into the result queue. The
// running cell sums live in a 64-entry RAM, one entry per cell column, which is read when a
// sample is taken and written in the following cycle, with a bypass for back-to-back samples
// of the same cell column. A four-entry result queue lets input continue while the consumer
// stalls; input ready drops only when that queue could otherwise overflow. Configuration
// registers are taken at any time but must be written only while no request is in flight.
module cell_sum_pooling_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [csp_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [csp_pkg::SUM_W-1:0]    cell_sum_o,
  output logic [csp_pkg::POS_W-1:0]           cell_row_o,
  output logic [csp_pkg::POS_W-1:0]           cell_col_o,
  output logic [csp_pkg::CHAN_W-1:0]          channel_o,
  output logic                                frame_last_o
);

  import csp_pkg::*;

  // Configuration registers.
  logic [4:0]  cell_size_q;
  logic [6:0]  cells_high_q;
  logic [6:0]  cells_wide_q;
  logic [12:0] image_rows_q;
  logic [12:0] image_cols_q;
  logic [4:0]  channel_count_q;

  // Clamped limits, stored as limit minus one.
  logic [CELL_W-1:0] cs_m1;
  logic [POS_W-1:0]  ch_m1;
  logic [POS_W-1:0]  cw_m1;
  logic [PIX_W-1:0]  rows_m1;
  logic [PIX_W-1:0]  cols_m1;
  logic [CHAN_W-1:0] cc_m1;
  logic [AREA_W-1:0] area_cols;
  logic [AREA_W-1:0] area_rows;

  // Position counters.
  logic [PIX_W-1:0]  pixel_col_q, pixel_col_d;
  logic [PIX_W-1:0]  pixel_row_q, pixel_row_d;
  logic [CHAN_W-1:0] plane_q, plane_d;
  logic [CELL_W-1:0] col_in_cell_q, col_in_cell_d;
  logic [CELL_W-1:0] row_in_cell_q, row_in_cell_d;
  logic [IDX_W-1:0]  cell_col_idx_q, cell_col_idx_d;
  logic [IDX_W-1:0]  cell_row_idx_q, cell_row_idx_d;

  // Accept-cycle decode.
  logic                    in_fire;
  logic                    col_in;
  logic                    row_in;
  logic                    acc_en;
  logic                    cell_end;
  logic [ADDR_W-1:0]       acc_addr;
  stage_t                  stage_d;

  // Accumulate stage.
  logic                    s1_valid_q;
  stage_t                  s1_q;
  logic signed [SUM_W-1:0] ram_rdata;
  logic signed [SUM_W-1:0] acc_base;
  logic signed [SUM_W-1:0] acc_sum;
  logic                    ram_we;
  logic                    push;

  // Result queue.
  result_t                 queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr_q;
  logic [QPTR_W-1:0]       rd_ptr_q;
  logic [QCNT_W-1:0]       count_q;
  logic                    pop;
  result_t                 head;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q     <= 5'd4;
      cells_high_q    <= 7'd1;
      cells_wide_q    <= 7'd1;
      image_rows_q    <= 13'd4;
      image_cols_q    <= 13'd4;
      channel_count_q <= 5'd1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CELL_SIZE:     cell_size_q     <= cfg_data_i[4:0];
        REG_CELLS_HIGH:    cells_high_q    <= cfg_data_i[6:0];
        REG_CELLS_WIDE:    cells_wide_q    <= cfg_data_i[6:0];
        REG_IMAGE_ROWS:    image_rows_q    <= cfg_data_i;
        REG_IMAGE_COLS:    image_cols_q    <= cfg_data_i;
        REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp each register into its legal range; zero reads as one.
  always_comb begin
    if (cell_size_q == 5'd0) begin
      cs_m1 = '0;
    end else if (cell_size_q > 5'(MAX_CELL_SIZE)) begin
      cs_m1 = CELL_W'(MAX_CELL_SIZE - 1);
    end else begin
      cs_m1 = CELL_W'(cell_size_q - 5'd1);
    end

    if (cells_high_q == 7'd0) begin
      ch_m1 = '0;
    end else if (cells_high_q > 7'(MAX_CELLS_HIGH)) begin
      ch_m1 = POS_W'(MAX_CELLS_HIGH - 1);
    end else begin
      ch_m1 = POS_W'(cells_high_q - 7'd1);
    end

    if (cells_wide_q == 7'd0) begin
      cw_m1 = '0;
    end else if (cells_wide_q > 7'(MAX_CELLS_WIDE)) begin
      cw_m1 = POS_W'(MAX_CELLS_WIDE - 1);
    end else begin
      cw_m1 = POS_W'(cells_wide_q - 7'd1);
    end

    if (image_rows_q == 13'd0) begin
      rows_m1 = '0;
    end else if (image_rows_q > 13'(MAX_IMAGE_DIM)) begin
      rows_m1 = PIX_W'(MAX_IMAGE_DIM - 1);
    end else begin
      rows_m1 = PIX_W'(image_rows_q - 13'd1);
    end

    if (image_cols_q == 13'd0) begin
      cols_m1 = '0;
    end else if (image_cols_q > 13'(MAX_IMAGE_DIM)) begin
      cols_m1 = PIX_W'(MAX_IMAGE_DIM - 1);
    end else begin
      cols_m1 = PIX_W'(image_cols_q - 13'd1);
    end

    if (channel_count_q == 5'd0) begin
      cc_m1 = '0;
    end else if (channel_count_q > 5'(MAX_CHANNELS)) begin
      cc_m1 = CHAN_W'(MAX_CHANNELS - 1);
    end else begin
      cc_m1 = CHAN_W'(channel_count_q - 5'd1);
    end
  end

  // Extent of the covered area in pixels.
  assign area_cols = (AREA_W'(cw_m1) + AREA_W'(1)) * (AREA_W'(cs_m1) + AREA_W'(1));
  assign area_rows = (AREA_W'(ch_m1) + AREA_W'(1)) * (AREA_W'(cs_m1) + AREA_W'(1));

  // Input is taken while the result queue has room for everything in flight.
  assign push       = s1_valid_q && s1_q.emit;
  assign in_ready_o = (count_q + QCNT_W'(push)) < QCNT_W'(QUEUE_DEPTH);
  assign in_fire    = in_valid_i && in_ready_o;

  // Decode the position of the current sample.
  assign col_in   = PIX_W'(pixel_col_q) < PIX_W'(area_cols);
  assign row_in   = PIX_W'(pixel_row_q) < PIX_W'(area_rows);
  assign acc_en   = col_in && row_in && (cell_col_idx_q < IDX_W'(MAX_CELLS_WIDE));
  assign cell_end = (row_in_cell_q >= cs_m1) && (col_in_cell_q >= cs_m1);
  assign acc_addr = cell_col_idx_q[ADDR_W-1:0];

  always_comb begin
    stage_d            = '0;
    stage_d.acc_en     = acc_en;
    stage_d.first      = (row_in_cell_q == '0) && (col_in_cell_q == '0);
    stage_d.emit       = acc_en && cell_end;
    stage_d.addr       = acc_addr;
    stage_d.sample     = SUM_W'(sample_i);
    // Bypass the entry that the accumulate stage writes in this same cycle.
    stage_d.fwd        = ram_we && (s1_q.addr == acc_addr);
    stage_d.fwd_data   = acc_sum;
    stage_d.cell_row   = cell_row_idx_q[POS_W-1:0];
    stage_d.cell_col   = cell_col_idx_q[POS_W-1:0];
    stage_d.channel    = plane_q;
    stage_d.frame_last = (cell_row_idx_q >= IDX_W'(ch_m1)) &&
                         (cell_col_idx_q >= IDX_W'(cw_m1)) &&
                         (plane_q >= cc_m1);
  end

  // Advance the raster counters for the accepted sample.
  always_comb begin
    pixel_col_d    = pixel_col_q;
    pixel_row_d    = pixel_row_q;
    plane_d        = plane_q;
    col_in_cell_d  = col_in_cell_q;
    row_in_cell_d  = row_in_cell_q;
    cell_col_idx_d = cell_col_idx_q;
    cell_row_idx_d = cell_row_idx_q;

    if (col_in) begin
      if (col_in_cell_q >= cs_m1) begin
        col_in_cell_d  = '0;
        cell_col_idx_d = cell_col_idx_q + IDX_W'(1);
      end else begin
        col_in_cell_d = col_in_cell_q + CELL_W'(1);
      end
    end

    if (pixel_col_q >= cols_m1) begin
      pixel_col_d    = '0;
      col_in_cell_d  = '0;
      cell_col_idx_d = '0;
      if (row_in) begin
        if (row_in_cell_q >= cs_m1) begin
          row_in_cell_d  = '0;
          cell_row_idx_d = cell_row_idx_q + IDX_W'(1);
        end else begin
          row_in_cell_d = row_in_cell_q + CELL_W'(1);
        end
      end
      if (pixel_row_q >= rows_m1) begin
        pixel_row_d    = '0;
        row_in_cell_d  = '0;
        cell_row_idx_d = '0;
        plane_d        = (plane_q >= cc_m1) ? '0 : plane_q + CHAN_W'(1);
      end else begin
        pixel_row_d = pixel_row_q + PIX_W'(1);
      end
    end else begin
      pixel_col_d = pixel_col_q + PIX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_col_q    <= '0;
      pixel_row_q    <= '0;
      plane_q        <= '0;
      col_in_cell_q  <= '0;
      row_in_cell_q  <= '0;
      cell_col_idx_q <= '0;
      cell_row_idx_q <= '0;
    end else if (in_fire) begin
      pixel_col_q    <= pixel_col_d;
      pixel_row_q    <= pixel_row_d;
      plane_q        <= plane_d;
      col_in_cell_q  <= col_in_cell_d;
      row_in_cell_q  <= row_in_cell_d;
      cell_col_idx_q <= cell_col_idx_d;
      cell_row_idx_q <= cell_row_idx_d;
    end
  end

  // Accumulate stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= stage_d;
    end
  end

  // Line of cell accumulators, one per cell column.
  csp_ram #(
    .Width (SUM_W),
    .Depth (MAX_CELLS_WIDE)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (acc_sum),
    .raddr_i (acc_addr),
    .rdata_o (ram_rdata)
  );

  // The first sample of a cell starts the sum; later ones add to it.
  assign acc_base = s1_q.fwd ? s1_q.fwd_data : ram_rdata;
  assign acc_sum  = s1_q.first ? s1_q.sample : acc_base + s1_q.sample;
  assign ram_we   = s1_valid_q && s1_q.acc_en;

  // Result queue write side.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= '{cell_sum:   acc_sum,
                             cell_row:   s1_q.cell_row,
                             cell_col:   s1_q.cell_col,
                             channel:    s1_q.channel,
                             frame_last: s1_q.frame_last};
    end
  end

  // Result queue pointers and fill count.
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Output side shows the oldest queued result.
  assign head         = queue_q[rd_ptr_q];
  assign out_valid_o  = count_q != '0;
  assign cell_sum_o   = head.cell_sum;
  assign cell_row_o   = head.cell_row;
  assign cell_col_o   = head.cell_col;
  assign channel_o    = head.channel;
  assign frame_last_o = head.frame_last;

endmodule
